// ----- design/qor_pkg.sv -----
// Shared types and widths for the quaternion offset rotation pipeline.
// No dependencies; every other design file imports this package.
package qor_pkg;

    // Port widths.
    localparam int QuatW = 16;
    localparam int OffW  = 16;
    localparam int PosW  = 24;

    // Engine vector: offset * 100 in units of 2^-12 cm; |v| <= 3276800.
    localparam int VecW  = 23;
    // Quaternion times engine vector; |q * v| < 2^37.
    localparam int ProdW = 38;
    // t = 2 * (q x v) in units of 2^-26 cm; |t| < 2^39.
    localparam int TW    = 40;
    // Quaternion times t; |q * t| < 2^54.
    localparam int MulW  = 55;
    // Rotated vector in units of 2^-40 cm; |r| < 2^56 with the rounding term.
    localparam int RotW  = 57;

    // Scale factor from metres to centimetres.
    localparam int CmPerM = 100;
    // Shift that takes 2^-40 cm down to 2^-8 cm.
    localparam int OutShift = 32;
    // Alignment of v (2^-12 cm) to the 2^-40 cm grid.
    localparam int VecShift = 28;

    typedef struct packed {
        logic signed [QuatW-1:0] w;
        logic signed [QuatW-1:0] x;
        logic signed [QuatW-1:0] y;
        logic signed [QuatW-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [VecW-1:0] x;
        logic signed [VecW-1:0] y;
        logic signed [VecW-1:0] z;
    } t_vvec;

    typedef struct packed {
        logic signed [TW-1:0] x;
        logic signed [TW-1:0] y;
        logic signed [TW-1:0] z;
    } t_tvec;

    typedef struct packed {
        logic signed [RotW-1:0] x;
        logic signed [RotW-1:0] y;
        logic signed [RotW-1:0] z;
    } t_rvec;

endpackage

// ----- design/qor_front.sv -----
// Input stage: remaps tracker axes to engine axes and scales metres to centimetres.
// Depends on qor_pkg.
module qor_front
    import qor_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_quat                   i_quat,
    input  logic signed [OffW-1:0]  i_off_x,
    input  logic signed [OffW-1:0]  i_off_y,
    input  logic signed [OffW-1:0]  i_off_z,
    output logic                    o_valid,
    output t_quat                   o_quat,
    output t_vvec                   o_vec
);

    localparam logic signed [VecW-1:0] Scale = VecW'(CmPerM);

    logic  r_valid;
    t_quat r_quat;
    t_vvec r_vec;
    t_vvec n_vec;

    // Forward is -z, right is -x, up is +y.
    always_comb begin
        n_vec.x = VecW'(0) - VecW'(i_off_z) * Scale;
        n_vec.y = VecW'(0) - VecW'(i_off_x) * Scale;
        n_vec.z = VecW'(i_off_y) * Scale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_quat <= i_quat;
        r_vec  <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_quat  = r_quat;
    assign o_vec   = r_vec;

endmodule

// ----- design/qor_tvec.sv -----
// Two stages that form t = 2 * (q x v): six products, then the differences.
// Depends on qor_pkg.
module qor_tvec
    import qor_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_quat  i_quat,
    input  t_vvec  i_vec,
    output logic   o_valid,
    output t_quat  o_quat,
    output t_vvec  o_vec,
    output t_tvec  o_t
);

    // Product stage.
    logic                    r_valid_a;
    t_quat                   r_quat_a;
    t_vvec                   r_vec_a;
    logic signed [ProdW-1:0] r_yz, r_zy, r_zx, r_xz, r_xy, r_yx;

    // Difference stage.
    logic  r_valid_b;
    t_quat r_quat_b;
    t_vvec r_vec_b;
    t_tvec r_t;
    t_tvec n_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
        end
        r_quat_a <= i_quat;
        r_vec_a  <= i_vec;
        r_yz <= ProdW'(i_quat.y) * ProdW'(i_vec.z);
        r_zy <= ProdW'(i_quat.z) * ProdW'(i_vec.y);
        r_zx <= ProdW'(i_quat.z) * ProdW'(i_vec.x);
        r_xz <= ProdW'(i_quat.x) * ProdW'(i_vec.z);
        r_xy <= ProdW'(i_quat.x) * ProdW'(i_vec.y);
        r_yx <= ProdW'(i_quat.y) * ProdW'(i_vec.x);
    end

    always_comb begin
        n_t.x = (TW'(r_yz) - TW'(r_zy)) <<< 1;
        n_t.y = (TW'(r_zx) - TW'(r_xz)) <<< 1;
        n_t.z = (TW'(r_xy) - TW'(r_yx)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else begin
            r_valid_b <= r_valid_a;
        end
        r_quat_b <= r_quat_a;
        r_vec_b  <= r_vec_a;
        r_t      <= n_t;
    end

    assign o_valid = r_valid_b;
    assign o_quat  = r_quat_b;
    assign o_vec   = r_vec_b;
    assign o_t     = r_t;

endmodule

// ----- design/qor_apply.sv -----
// Two stages that form v' = v + w*t + (q x t): nine products, then one sum per axis.
// Depends on qor_pkg.
module qor_apply
    import qor_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_quat  i_quat,
    input  t_vvec  i_vec,
    input  t_tvec  i_t,
    output logic   o_valid,
    output t_rvec  o_r
);

    logic                   r_valid_a;
    t_vvec                  r_vec_a;
    logic signed [MulW-1:0] r_wx, r_wy, r_wz;
    logic signed [MulW-1:0] r_ytz, r_zty, r_ztx, r_xtz, r_xty, r_ytx;

    logic  r_valid_b;
    t_rvec r_r;
    t_rvec n_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
        end
        r_vec_a <= i_vec;
        r_wx  <= MulW'(i_quat.w) * MulW'(i_t.x);
        r_wy  <= MulW'(i_quat.w) * MulW'(i_t.y);
        r_wz  <= MulW'(i_quat.w) * MulW'(i_t.z);
        r_ytz <= MulW'(i_quat.y) * MulW'(i_t.z);
        r_zty <= MulW'(i_quat.z) * MulW'(i_t.y);
        r_ztx <= MulW'(i_quat.z) * MulW'(i_t.x);
        r_xtz <= MulW'(i_quat.x) * MulW'(i_t.z);
        r_xty <= MulW'(i_quat.x) * MulW'(i_t.y);
        r_ytx <= MulW'(i_quat.y) * MulW'(i_t.x);
    end

    always_comb begin
        n_r.x = (RotW'(r_vec_a.x) <<< VecShift) + RotW'(r_wx) + RotW'(r_ytz) - RotW'(r_zty);
        n_r.y = (RotW'(r_vec_a.y) <<< VecShift) + RotW'(r_wy) + RotW'(r_ztx) - RotW'(r_xtz);
        n_r.z = (RotW'(r_vec_a.z) <<< VecShift) + RotW'(r_wz) + RotW'(r_xty) - RotW'(r_ytx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else begin
            r_valid_b <= r_valid_a;
        end
        r_r <= n_r;
    end

    assign o_valid = r_valid_b;
    assign o_r     = r_r;

endmodule

// ----- design/qor_sat.sv -----
// Output stage: rounds 2^-40 cm down to 2^-8 cm (half up) and saturates to 24 bits.
// Depends on qor_pkg.
module qor_sat
    import qor_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_rvec                  i_r,
    output logic                   o_valid,
    output logic signed [PosW-1:0] o_pos_x,
    output logic signed [PosW-1:0] o_pos_y,
    output logic signed [PosW-1:0] o_pos_z
);

    localparam int HiW = RotW - OutShift;
    localparam logic signed [RotW-1:0] Half = RotW'(1) <<< (OutShift - 1);

    function automatic logic signed [PosW-1:0] round_sat(input logic signed [RotW-1:0] a);
        logic signed [RotW-1:0] s;
        logic signed [HiW-1:0]  h;
        logic signed [PosW-1:0] res;
        s = a + Half;
        h = s[RotW-1:OutShift];
        // The result fits when the bits above the output sign all match it.
        if (h[HiW-1:PosW-1] == {(HiW-PosW+1){1'b0}} ||
            h[HiW-1:PosW-1] == {(HiW-PosW+1){1'b1}}) begin
            res = h[PosW-1:0];
        end else if (h[HiW-1]) begin
            res = {1'b1, {(PosW-1){1'b0}}};
        end else begin
            res = {1'b0, {(PosW-1){1'b1}}};
        end
        return res;
    endfunction

    logic                   r_valid;
    logic signed [PosW-1:0] r_pos_x, r_pos_y, r_pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_pos_x <= round_sat(i_r.x);
        r_pos_y <= round_sat(i_r.y);
        r_pos_z <= round_sat(i_r.z);
    end

    assign o_valid = r_valid;
    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_pos_z = r_pos_z;

    // For x and z: rounding and saturation never turn a nonnegative sum negative.
    a_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_pos_x[PosW-1] |-> $past(i_r.x[RotW-1]))
        else $error("pos_x negative from a nonnegative sum");
    a_sign_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_pos_z[PosW-1] |-> $past(i_r.z[RotW-1]))
        else $error("pos_z negative from a nonnegative sum");

endmodule

// ----- design/quaternion_offset_rotate.sv -----
// Top level of the quaternion offset rotation pipeline.
// Depends on qor_pkg, qor_front, qor_tvec, qor_apply and qor_sat.
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      quat_w/x/y/z (Q1.14), offset_x/y/z
// result    out        o_valid strobe, 1 cycle   o_pos_x/y/z (2^-8 cm, saturated)
//
// Every transaction runs through six register stages: axis remap and scale, six
// vector products, the differences that form t, nine products with t, the per-axis
// sum, and rounding with saturation. The result strobe comes from the last stage, and
// a new transaction can be taken at every clock edge, so busy stays low. Reset clears
// only the valid bits of the stages, and the receiver cannot stall the result
// channel.
module quaternion_offset_rotate
    import qor_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [QuatW-1:0] i_quat_w,
    input  logic signed [QuatW-1:0] i_quat_x,
    input  logic signed [QuatW-1:0] i_quat_y,
    input  logic signed [QuatW-1:0] i_quat_z,
    input  logic signed [OffW-1:0]  i_offset_x,
    input  logic signed [OffW-1:0]  i_offset_y,
    input  logic signed [OffW-1:0]  i_offset_z,
    output logic                    o_valid,
    output logic signed [PosW-1:0]  o_pos_x,
    output logic signed [PosW-1:0]  o_pos_y,
    output logic signed [PosW-1:0]  o_pos_z
);

    // Stages from the accepting edge to the edge that samples the result.
    localparam int PipeDepth = 6;

    t_quat in_quat;
    logic  accept;

    logic  fr_valid;
    t_quat fr_quat;
    t_vvec fr_vec;

    logic  tv_valid;
    t_quat tv_quat;
    t_vvec tv_vec;
    t_tvec tv_t;

    logic  ap_valid;
    t_rvec ap_r;

    // Nothing in the pipeline ever holds a transaction back.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        in_quat.w = i_quat_w;
        in_quat.x = i_quat_x;
        in_quat.y = i_quat_y;
        in_quat.z = i_quat_z;
    end

    qor_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_quat  (in_quat),
        .i_off_x (i_offset_x),
        .i_off_y (i_offset_y),
        .i_off_z (i_offset_z),
        .o_valid (fr_valid),
        .o_quat  (fr_quat),
        .o_vec   (fr_vec)
    );

    qor_tvec u_tvec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_quat  (fr_quat),
        .i_vec   (fr_vec),
        .o_valid (tv_valid),
        .o_quat  (tv_quat),
        .o_vec   (tv_vec),
        .o_t     (tv_t)
    );

    qor_apply u_apply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tv_valid),
        .i_quat  (tv_quat),
        .i_vec   (tv_vec),
        .i_t     (tv_t),
        .o_valid (ap_valid),
        .o_r     (ap_r)
    );

    qor_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ap_valid),
        .i_r     (ap_r),
        .o_valid (o_valid),
        .o_pos_x (o_pos_x),
        .o_pos_y (o_pos_y),
        .o_pos_z (o_pos_z)
    );

    // Every accepted transaction yields a result at the end of the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##PipeDepth o_valid)
        else $error("accepted transaction produced no result");

    // No result appears without a transaction accepted at the head of the pipeline.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, PipeDepth))
        else $error("result without a matching transaction");

    // Halfway down the pipe, the valid bit still tracks the accepting edge.
    a_mid_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tv_valid |-> $past(accept, 3))
        else $error("mid-pipeline valid out of step");

endmodule
